// ===== hw/rtl/stq_pkg.sv =====
// ============================================================================
// stq_pkg: shared types and constants of the sorted timer event queue
// Pool size, link width, status codes and the request kinds.
// ============================================================================
package stq_pkg;

    localparam int PoolDepth = 32;
    localparam int LinkBits  = $clog2(PoolDepth + 1);
    localparam int IdxBits   = $clog2(PoolDepth);
    localparam int TagBits   = 8;

    localparam logic [31:0] TpsReset = 32'd24000000;

    typedef logic [LinkBits-1:0] link_t;
    typedef logic [IdxBits-1:0]  idx_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_BAD     = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_SERVICE = 1'b1;

    localparam link_t NilLink = link_t'(PoolDepth);

    // Request to the entry memory: one read port, one write port.
    typedef struct packed {
        logic         rd_en;
        idx_t         rd_idx;
        logic         wr_en;
        idx_t         wr_idx;
        logic         wr_data_en;
        logic [63:0]  wr_expiry;
        logic [TagBits-1:0] wr_tag;
        link_t        wr_link;
    } mem_req_t;

    typedef struct packed {
        logic [63:0]  expiry;
        logic [TagBits-1:0] tag;
        link_t        link;
    } mem_rsp_t;

    function automatic link_t norm_link(input link_t v);
        return (v < link_t'(PoolDepth)) ? v : NilLink;
    endfunction

endpackage

// ===== hw/rtl/stq_entry_mem.sv =====
// ============================================================================
// stq_entry_mem: entry storage of the timer pool
// Synchronous memories for expiry, tag and link; read data is registered.
// The link memory resets to a chained free list by a sweep after reset.
// ============================================================================
module stq_entry_mem
    import stq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp,
    output logic     init_done
);

    logic [63:0]        expiry_mem [PoolDepth];
    logic [TagBits-1:0] tag_mem    [PoolDepth];
    link_t              link_mem   [PoolDepth];

    logic [LinkBits-1:0] init_cnt_reg;
    logic                init_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == link_t'(PoolDepth - 1))
            begin
                init_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            link_mem[init_cnt_reg[IdxBits-1:0]] <= init_cnt_reg + 1'b1;
        end
        else if (req.wr_en)
        begin
            link_mem[req.wr_idx] <= req.wr_link;
            if (req.wr_data_en)
            begin
                expiry_mem[req.wr_idx] <= req.wr_expiry;
                tag_mem[req.wr_idx]    <= req.wr_tag;
            end
        end
        if (req.rd_en)
        begin
            rsp.expiry <= expiry_mem[req.rd_idx];
            rsp.tag    <= tag_mem[req.rd_idx];
            rsp.link   <= link_mem[req.rd_idx];
        end
    end

    assign init_done = init_done_reg;

endmodule

// ===== hw/rtl/sorted_timer_event_queue.sv =====
// ============================================================================
// sorted_timer_event_queue: sorted software timer list in hardware
// Adds timers into an expiry-sorted linked list and pops expired entries.
// ============================================================================
// Channel     | Ports                                       | Handshake
// request     | kind now delay_seconds event_tag            | start, busy
// result      | status expired_tag compare_value            | result_valid
//             | timer_irq_enable last                       |
// config      | ticks_per_second_data                       | ticks_per_second_we
//
// An add that lands at the list head goes through MUL, HEADRD and HEADCHK to
// FIN; one placed further back also walks the list in WALKRD and WALKCHK and
// links the new entry in LINK. A service runs SVRD, SVCHK and SVFREE for each
// popped entry and ends in FIN. Every list step waits for its read from the
// single memory read port. After reset a sweep chains the free list; busy is
// high meanwhile. Results cannot be stalled; each is shown for one cycle.
// ============================================================================
module sorted_timer_event_queue
    import stq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [63:0]        now,
    input  logic signed [31:0] delay_seconds,
    input  logic [7:0]         event_tag,
    input  logic               ticks_per_second_we,
    input  logic [31:0]        ticks_per_second_data,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic [7:0]         expired_tag,
    output logic [63:0]        compare_value,
    output logic               timer_irq_enable,
    output logic               last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_HEADRD,
        S_HEADCHK,
        S_WALKRD,
        S_WALKCHK,
        S_LINK,
        S_SVRD,
        S_SVCHK,
        S_SVFREE,
        S_FIN
    } state_t;

    state_t state_reg;
    logic [31:0] tps_reg;
    logic [63:0] now_reg;
    logic [31:0] dly_reg;
    logic [7:0]  tag_reg;
    logic [63:0] exp_reg;
    link_t       active_head_reg;
    link_t       free_head_reg;
    link_t       new_reg;
    link_t       cur_reg;
    link_t       nxt_reg;
    link_t       fl_next_reg;
    status_t     st_reg;
    logic [7:0]  etag_reg;

    mem_req_t req;
    mem_rsp_t rsp;
    logic     init_done;

    stq_entry_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .init_done (init_done)
    );

    logic  accept;
    link_t rsp_link;
    assign accept   = start && !busy;
    assign rsp_link = norm_link(rsp.link);

    always_comb
    begin
        req = '0;
        req.wr_expiry = exp_reg;
        req.wr_tag    = tag_reg;
        unique case (state_reg)
            S_MUL:
            begin
                req.rd_en  = 1'b1;
                req.rd_idx = free_head_reg[IdxBits-1:0];
            end
            S_HEADRD:
            begin
                req.rd_en  = 1'b1;
                req.rd_idx = active_head_reg[IdxBits-1:0];
            end
            S_WALKRD:
            begin
                req.rd_en  = 1'b1;
                req.rd_idx = nxt_reg[IdxBits-1:0];
            end
            S_LINK:
            begin
                req.wr_en      = 1'b1;
                req.wr_idx     = cur_reg[IdxBits-1:0];
                req.wr_link    = new_reg;
            end
            S_SVRD:
            begin
                req.rd_en  = 1'b1;
                req.rd_idx = active_head_reg[IdxBits-1:0];
            end
            S_SVFREE:
            begin
                req.wr_en   = 1'b1;
                req.wr_idx  = cur_reg[IdxBits-1:0];
                req.wr_link = free_head_reg;
            end
            default:
            begin
            end
        endcase
        // New entry write happens in HEADCHK or WALKCHK when the spot is known.
        if ((state_reg == S_HEADCHK && active_head_reg != NilLink
                && !(exp_reg < rsp.expiry))
            || state_reg == S_HEADCHK && active_head_reg == NilLink)
        begin
            if (active_head_reg == NilLink)
            begin
                req.wr_en      = 1'b1;
                req.wr_data_en = 1'b1;
                req.wr_idx     = new_reg[IdxBits-1:0];
                req.wr_link    = NilLink;
            end
        end
        else if (state_reg == S_HEADCHK)
        begin
            req.wr_en      = 1'b1;
            req.wr_data_en = 1'b1;
            req.wr_idx     = new_reg[IdxBits-1:0];
            req.wr_link    = active_head_reg;
        end
        if (state_reg == S_WALKCHK
            && (nxt_reg == NilLink || rsp.expiry > exp_reg))
        begin
            req.wr_en      = 1'b1;
            req.wr_data_en = 1'b1;
            req.wr_idx     = new_reg[IdxBits-1:0];
            req.wr_link    = nxt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tps_reg         <= TpsReset;
            active_head_reg <= NilLink;
            free_head_reg   <= '0;
            st_reg          <= ST_DONE;
            etag_reg        <= '0;
        end
        else
        begin
            if (ticks_per_second_we)
            begin
                tps_reg <= ticks_per_second_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg  <= now;
                        dly_reg  <= delay_seconds;
                        tag_reg  <= event_tag;
                        if (kind == KIND_SERVICE)
                        begin
                            state_reg <= S_SVRD;
                        end
                        else if (delay_seconds[31] || event_tag == '0)
                        begin
                            st_reg    <= ST_BAD;
                            state_reg <= S_FIN;
                        end
                        else if (free_head_reg == NilLink)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    exp_reg   <= dly_reg * tps_reg;
                    new_reg   <= free_head_reg;
                    state_reg <= S_HEADRD;
                end
                S_HEADRD:
                begin
                    exp_reg     <= now_reg + exp_reg;
                    fl_next_reg <= rsp_link;
                    state_reg   <= S_HEADCHK;
                end
                S_HEADCHK:
                begin
                    free_head_reg <= fl_next_reg;
                    st_reg        <= ST_ADDED;
                    if (active_head_reg == NilLink || exp_reg < rsp.expiry)
                    begin
                        active_head_reg <= new_reg;
                        state_reg       <= S_FIN;
                    end
                    else
                    begin
                        cur_reg   <= active_head_reg;
                        nxt_reg   <= rsp_link;
                        state_reg <= (rsp_link == NilLink) ? S_WALKCHK : S_WALKRD;
                    end
                end
                S_WALKRD:
                begin
                    state_reg <= S_WALKCHK;
                end
                S_WALKCHK:
                begin
                    if (nxt_reg == NilLink || rsp.expiry > exp_reg)
                    begin
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        cur_reg   <= nxt_reg;
                        nxt_reg   <= rsp_link;
                        state_reg <= (rsp_link == NilLink) ? S_WALKCHK : S_WALKRD;
                    end
                end
                S_LINK:
                begin
                    state_reg <= S_FIN;
                end
                S_SVRD:
                begin
                    if (active_head_reg == NilLink)
                    begin
                        st_reg    <= ST_DONE;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SVCHK;
                    end
                end
                S_SVCHK:
                begin
                    if (rsp.expiry > now_reg)
                    begin
                        st_reg    <= ST_DONE;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cur_reg         <= active_head_reg;
                        active_head_reg <= rsp_link;
                        etag_reg        <= rsp.tag;
                        state_reg       <= S_SVFREE;
                    end
                end
                S_SVFREE:
                begin
                    // Popped entry goes to the free list head; it is reported
                    // once the new head expiry is known.
                    free_head_reg <= cur_reg;
                    st_reg        <= ST_EXPIRED;
                    state_reg     <= S_SVRD;
                end
                S_FIN:
                begin
                    etag_reg     <= '0;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Head expiry for the final result: captured from adds and service reads.
    logic [63:0] head_val;
    logic [63:0] hv_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_HEADCHK
            && (active_head_reg == NilLink || exp_reg < rsp.expiry))
        begin
            hv_reg <= exp_reg;
        end
        else if (state_reg == S_SVCHK)
        begin
            hv_reg <= rsp.expiry;
        end
    end
    assign head_val = hv_reg;

    // An expired result waits for the next head read, so that it carries the
    // compare value left after its pop.
    logic        pend_reg;
    logic [7:0]  pend_tag_reg;
    logic        out_v_reg;
    status_t     out_st_reg;
    logic [7:0]  out_tag_reg;
    logic        out_last_reg;
    logic [63:0] out_cmp_reg;
    logic        out_irq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            pend_tag_reg <= '0;
            out_v_reg    <= 1'b0;
            out_st_reg   <= ST_DONE;
            out_tag_reg  <= '0;
            out_last_reg <= 1'b0;
            out_cmp_reg  <= '1;
            out_irq_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= 1'b0;
            if (state_reg == S_SVCHK && pend_reg)
            begin
                // Report the previous pop with the head expiry now read.
                out_v_reg    <= 1'b1;
                out_st_reg   <= ST_EXPIRED;
                out_tag_reg  <= pend_tag_reg;
                out_last_reg <= 1'b0;
                out_cmp_reg  <= rsp.expiry;
                out_irq_reg  <= 1'b1;
                pend_reg     <= 1'b0;
            end
            else if (state_reg == S_SVRD && pend_reg && active_head_reg == NilLink)
            begin
                out_v_reg    <= 1'b1;
                out_st_reg   <= ST_EXPIRED;
                out_tag_reg  <= pend_tag_reg;
                out_last_reg <= 1'b0;
                out_cmp_reg  <= '1;
                out_irq_reg  <= 1'b0;
                pend_reg     <= 1'b0;
            end
            else if (state_reg == S_SVFREE)
            begin
                pend_reg     <= 1'b1;
                pend_tag_reg <= etag_reg;
            end
            else if (state_reg == S_FIN)
            begin
                out_v_reg    <= 1'b1;
                out_st_reg   <= st_reg;
                out_tag_reg  <= '0;
                out_last_reg <= 1'b1;
                out_cmp_reg  <= (active_head_reg == NilLink) ? '1 : head_val;
                out_irq_reg  <= (active_head_reg != NilLink);
            end
        end
    end

    assign busy             = (state_reg != S_IDLE) || !init_done;
    assign result_valid     = out_v_reg;
    assign status           = out_st_reg;
    assign expired_tag      = out_tag_reg;
    assign compare_value    = out_cmp_reg;
    assign timer_irq_enable = out_irq_reg;
    assign last             = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("back-to-back final results");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_EXPIRED |-> !last)
        else $error("expired result marked last");
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// tb: testbench of the sorted timer event queue
// Sends add and service requests and checks every result against a model.
// A behavioral copy of the timer list predicts each result. The run starts
// with a table of directed requests, then runs random phases under several
// ticks_per_second settings. The phases mix well-formed timer traffic with
// rejected adds and random noise.
// ============================================================================
module tb;
    import stq_pkg::*;

    localparam int Nil       = PoolDepth;
    localparam int StallMax  = 3000;
    localparam logic [63:0] AllOnes = '1;

    typedef struct {
        status_t     st;
        logic [7:0]  tag;
        logic [63:0] cmp;
        logic        irq;
        logic        fin;
    } timer_result_t;

    typedef struct {
        logic        kind;
        logic [63:0] now;
        logic [31:0] delay;
        logic [7:0]  tag;
        logic        typed;
        status_t     st;
        logic [63:0] cmp;
    } req_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic [63:0]        now;
    logic signed [31:0] delay_seconds;
    logic [7:0]         event_tag;
    logic               ticks_per_second_we;
    logic [31:0]        ticks_per_second_data;
    logic               result_valid;
    logic [2:0]         status;
    logic [7:0]         expired_tag;
    logic [63:0]        compare_value;
    logic               timer_irq_enable;
    logic               last;

    // Model of the timer list.
    logic [63:0] mdl_expiry [PoolDepth];
    logic [7:0]  mdl_tag    [PoolDepth];
    int          mdl_link   [PoolDepth];
    int          mdl_head;
    int          mdl_free;
    logic [31:0] mdl_tps;

    timer_result_t pending_results[$];
    int  errors;
    int  stall_cycles;
    int  requests_sent;
    int  results_seen;
    int  expired_seen;
    int  full_seen;
    bit  idle_on;
    logic [63:0] clock_now;

    sorted_timer_event_queue dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .start                 (start),
        .busy                  (busy),
        .kind                  (kind),
        .now                   (now),
        .delay_seconds         (delay_seconds),
        .event_tag             (event_tag),
        .ticks_per_second_we   (ticks_per_second_we),
        .ticks_per_second_data (ticks_per_second_data),
        .result_valid          (result_valid),
        .status                (status),
        .expired_tag           (expired_tag),
        .compare_value         (compare_value),
        .timer_irq_enable      (timer_irq_enable),
        .last                  (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic push_result(input status_t st, input logic [7:0] tag, input logic fin);
        timer_result_t r;
        r.st  = st;
        r.tag = tag;
        r.fin = fin;
        r.irq = (mdl_head != Nil);
        r.cmp = (mdl_head != Nil) ? mdl_expiry[mdl_head] : AllOnes;
        pending_results.push_back(r);
    endtask

    task automatic predict_request(input logic k, input logic [63:0] t,
                                   input logic [31:0] d, input logic [7:0] tg);
        int n;
        int cur;
        int nxt;
        int steps;
        logic [63:0] due;
        if (k == KIND_ADD) begin
            if (d[31] || tg == 8'd0) begin
                push_result(ST_BAD, 8'd0, 1'b1);
                return;
            end
            if (mdl_free == Nil) begin
                push_result(ST_FULL, 8'd0, 1'b1);
                return;
            end
            n = mdl_free;
            mdl_free = mdl_link[n];
            due = t + 64'(d) * 64'(mdl_tps);
            mdl_expiry[n] = due;
            mdl_tag[n] = tg;
            cur = mdl_head;
            if (cur == Nil || due < mdl_expiry[cur]) begin
                mdl_link[n] = cur;
                mdl_head = n;
            end
            else begin
                // Walk past every entry that expires at or before the new one.
                for (steps = 0; steps < PoolDepth; steps++) begin
                    nxt = mdl_link[cur];
                    if (nxt == Nil || mdl_expiry[nxt] > due)
                        break;
                    cur = nxt;
                end
                mdl_link[n] = mdl_link[cur];
                mdl_link[cur] = n;
            end
            push_result(ST_ADDED, 8'd0, 1'b1);
        end
        else begin
            while (mdl_head != Nil && mdl_expiry[mdl_head] <= t) begin
                n = mdl_head;
                mdl_head = mdl_link[n];
                mdl_link[n] = mdl_free;
                mdl_free = n;
                push_result(ST_EXPIRED, mdl_tag[n], 1'b0);
            end
            push_result(ST_DONE, 8'd0, 1'b1);
        end
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        timer_result_t e;
        if (rst_n) begin
            if (result_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (result_valid) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result status=%0d tag=%0d cmp=%h",
                             $time, status, expired_tag, compare_value);
                end
                else begin
                    e = pending_results.pop_front();
                    if (status !== e.st || expired_tag !== e.tag || compare_value !== e.cmp
                        || timer_irq_enable !== e.irq || last !== e.fin) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d tag=%0d cmp=%h irq=%b last=%b",
                                 $time, e.st, e.tag, e.cmp, e.irq, e.fin);
                        $display("%0t:          actual st=%0d tag=%0d cmp=%h irq=%b last=%b",
                                 $time, status, expired_tag, compare_value,
                                 timer_irq_enable, last);
                    end
                    if (e.st == ST_EXPIRED)
                        expired_seen++;
                    if (e.st == ST_FULL)
                        full_seen++;
                end
            end
            if (start && !busy) begin
                requests_sent++;
                predict_request(kind, now, delay_seconds, event_tag);
            end
            if (stall_cycles >= StallMax) begin
                $display("%0t: watchdog expired", $time);
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic k, input logic [63:0] t,
                                input logic [31:0] d, input logic [7:0] tg);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 6);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = k;
        now = t;
        delay_seconds = d;
        event_tag = tg;
        start = 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle_and_set_tps(input logic [31:0] value);
        @(negedge clk);
        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (80) @(negedge clk);
        ticks_per_second_we = 1'b1;
        ticks_per_second_data = value;
        mdl_tps = value;
        @(negedge clk);
        ticks_per_second_we = 1'b0;
    endtask

    task automatic random_phase(input int count, input int add_pct);
        logic [63:0] t;
        logic [31:0] d;
        logic [7:0]  tg;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            tg = 8'($urandom_range(1, 255));
            if (pick < add_pct) begin
                d = 32'($urandom_range(0, 4));
                t = clock_now;
                case ($urandom_range(9))
                    0: d = $urandom();
                    1: tg = 8'd0;
                    2: t = {$urandom(), $urandom()};
                    default: ;
                endcase
                send_request(KIND_ADD, t, d, tg);
            end
            else begin
                clock_now = clock_now + 64'($urandom_range(0, 3)) * 64'(mdl_tps)
                            + 64'($urandom_range(0, 1000));
                t = ($urandom_range(19) == 0) ? {$urandom(), $urandom()} : clock_now;
                send_request(KIND_SERVICE, t, $urandom(), 8'($urandom()));
            end
        end
    endtask

    initial
    begin
        req_row_t rows[$];
        req_row_t r;
        int i;
        errors = 0;
        stall_cycles = 0;
        requests_sent = 0;
        results_seen = 0;
        expired_seen = 0;
        full_seen = 0;
        idle_on = 1'b1;
        clock_now = 64'd0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_ADD;
        now = '0;
        delay_seconds = '0;
        event_tag = '0;
        ticks_per_second_we = 1'b0;
        ticks_per_second_data = '0;
        mdl_tps = TpsReset;
        mdl_head = Nil;
        mdl_free = 0;
        for (i = 0; i < PoolDepth; i++)
        begin
            mdl_link[i] = i + 1;
            mdl_expiry[i] = '0;
            mdl_tag[i] = '0;
        end

        // kind, now, delay, tag, typed, status, compare value
        rows = '{
            '{KIND_SERVICE, 64'd0, 32'd0, 8'd0, 1'b1, ST_DONE, AllOnes},
            '{KIND_ADD, 64'd5, 32'hFFFF_FFFF, 8'd5, 1'b1, ST_BAD, AllOnes},
            '{KIND_ADD, 64'd5, 32'h8000_0000, 8'hFF, 1'b1, ST_BAD, AllOnes},
            '{KIND_ADD, 64'd5, 32'd1, 8'd0, 1'b1, ST_BAD, AllOnes},
            '{KIND_ADD, 64'd100, 32'd0, 8'd1, 1'b1, ST_ADDED, 64'd100},
            '{KIND_ADD, 64'd100, 32'd0, 8'd2, 1'b1, ST_ADDED, 64'd100},
            '{KIND_ADD, 64'd0, 32'd1, 8'h80, 1'b0, ST_ADDED, 64'd0},
            '{KIND_ADD, AllOnes, 32'h7FFF_FFFF, 8'hFF, 1'b0, ST_ADDED, 64'd0},
            '{KIND_ADD, AllOnes, 32'd0, 8'h7F, 1'b0, ST_ADDED, 64'd0},
            '{KIND_ADD, 64'd50, 32'd0, 8'd3, 1'b1, ST_ADDED, 64'd50},
            '{KIND_SERVICE, 64'd99, 32'd0, 8'd0, 1'b0, ST_DONE, 64'd0},
            '{KIND_SERVICE, 64'd100, 32'hFFFF_FFFF, 8'hFF, 1'b0, ST_DONE, 64'd0},
            '{KIND_SERVICE, AllOnes, 32'd0, 8'd0, 1'b1, ST_DONE, AllOnes},
            '{KIND_SERVICE, 64'd0, 32'd0, 8'd0, 1'b1, ST_DONE, AllOnes}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[j])
        begin
            r = rows[j];
            send_request(r.kind, r.now, r.delay, r.tag);
            if (r.typed) begin
                @(negedge clk);
                if (pending_results.size() == 0 || pending_results[$].st != r.st
                    || pending_results[$].cmp != r.cmp) begin
                    errors++;
                    $display("%0t: row %0d expected st=%0d cmp=%h", $time, j, r.st, r.cmp);
                end
            end
        end

        // Phases under different tick rates, extremes among them.
        settle_and_set_tps(32'd1);
        random_phase(50, 85);
        settle_and_set_tps(32'hFFFF_FFFF);
        random_phase(50, 60);
        idle_on = 1'b0;
        settle_and_set_tps($urandom());
        random_phase(50, 70);
        idle_on = 1'b1;
        settle_and_set_tps(32'd1000);
        random_phase(60, 90);
        settle_and_set_tps(TpsReset);
        random_phase(50, 40);

        @(negedge clk);
        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (120) @(posedge clk);
        $display("Covered %0d requests and %0d results: %0d expired timers, %0d pool-full adds.",
                 requests_sent, results_seen, expired_seen, full_seen);
        $display("Five tick rates were used, from 1 up to the 32-bit maximum.");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
